>>> rtl/bmsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_pkg
// Shared types and codes of the binary square-window morphology block.
// ----------------------------------------------------------------------------
package bmsw_pkg;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_RADIUS       = 2'd2;
  localparam cfg_idx_t CFG_OPERATION    = 2'd3;

  localparam int unsigned CFG_DATA_W = 11;

  // Reset values of the configuration
  localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [2:0]            RST_RADIUS = 3'd1;

  typedef enum logic [1:0] {
    OP_DILATE = 2'd0,
    OP_ERODE  = 2'd1,
    OP_OPEN   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  // One item leaving a window stage
  typedef struct packed {
    logic vld;   // stage produced an item
    logic val;   // window result
    logic inf;   // center pixel lies inside the frame
    logic last;  // center is the frame's final pixel
    logic fend;  // item closes the frame
  } item_t;

endpackage

>>> rtl/bmsw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmsw_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/bmsw_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_stage
// One square-window dilate/erode stage: column line store, window register,
// frame-edge masks and the reduction, three register levels deep.
// ----------------------------------------------------------------------------
module bmsw_stage #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        clr_i,
  input  logic                                        dil_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]              w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]             h_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]             r_i,
  input  logic [$clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1)-1:0] d_i,
  input  logic                                        in_vld_i,
  input  logic                                        in_pix_i,
  input  logic                                        in_fend_i,
  output bmsw_pkg::item_t                             out_o
);
  import bmsw_pkg::*;

  localparam int unsigned WW  = $clog2(MAX_WIDTH+1);
  localparam int unsigned RB  = $clog2(MAX_RADIUS+1);
  localparam int unsigned DW  = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT+4*MAX_RADIUS+2);
  localparam int unsigned WIN = 2*MAX_RADIUS+1;
  localparam int unsigned SC  = CW + 6;
  localparam int unsigned SR  = RW + 6;

  // Input position and window-center counters
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] ccol_q, ccol_d;
  logic [RW-1:0] crow_q, crow_d;
  logic [DW-1:0] cnt_q, cnt_d;
  logic          act_q, act_d;
  logic          acc;

  assign acc = in_vld_i & adv_i;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ccol_d = ccol_q;
    crow_d = crow_q;
    cnt_d  = cnt_q;
    act_d  = act_q;
    if (clr_i || (acc && in_fend_i)) begin
      col_d  = '0;
      row_d  = '0;
      ccol_d = '0;
      crow_d = '0;
      cnt_d  = '0;
      act_d  = 1'b0;
    end else if (acc) begin
      if (WW'(col_q) == w_i - 1'b1) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (act_q) begin
        if (WW'(ccol_q) == w_i - 1'b1) begin
          ccol_d = '0;
          crow_d = crow_q + 1'b1;
        end else begin
          ccol_d = ccol_q + 1'b1;
        end
      end else if (cnt_q == d_i - 1'b1) begin
        act_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ccol_q <= '0;
      crow_q <= '0;
      cnt_q  <= '0;
      act_q  <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ccol_q <= ccol_d;
      crow_q <= crow_d;
      cnt_q  <= cnt_d;
      act_q  <= act_d;
    end
  end

  // Level B: line store read returns, column vector is built
  logic          vld_b_q, pix_b_q, emit_b_q, inf_b_q, last_b_q, fend_b_q;
  logic [CW-1:0] col_b_q, ccol_b_q;
  logic [RW-1:0] crow_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (adv_i) begin
      vld_b_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_b_q  <= in_pix_i & (row_q < RW'(h_i));
      emit_b_q <= act_q;
      inf_b_q  <= crow_q < RW'(h_i);
      last_b_q <= (WW'(ccol_q) == w_i - 1'b1) && (crow_q == RW'(h_i) - 1'b1);
      fend_b_q <= in_fend_i;
      col_b_q  <= col_q;
      ccol_b_q <= ccol_q;
      crow_b_q <= crow_q;
    end
  end

  // Line store: per column, the 2R rows above the current one
  logic               we;
  logic [WIN-2:0]     rdata, hist, fwd_data_q;
  logic [WIN-1:0]     vec;
  logic               fwd_q;

  assign we   = vld_b_q & adv_i;
  assign hist = fwd_q ? fwd_data_q : rdata;
  assign vec  = {hist, pix_b_q};

  bmsw_ram #(
    .WIDTH (WIN-1),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_b_q),
    .wdata_i (vec[WIN-2:0]),
    .re_i    (adv_i),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // Forward a write that collides with the read of the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (adv_i) begin
      fwd_q <= we && (col_q == col_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_data_q <= vec[WIN-2:0];
    end
  end

  // Window register, slot 0 holds the newest column
  logic [WIN-1:0] win_q [WIN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WIN; j++) begin
        win_q[j] <= '0;
      end
    end else if (we) begin
      win_q[0] <= vec;
      for (int j = 1; j < WIN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // Frame-edge masks for the center held in level B
  logic [WIN-1:0] cm, rm, rng;

  always_comb begin
    logic signed [SC-1:0] cv;
    logic signed [SR-1:0] rv;
    for (int j = 0; j < WIN; j++) begin
      rng[j] = (RB+1)'(j) <= {r_i, 1'b0};
      cv = $signed(SC'(ccol_b_q)) + $signed(SC'(r_i)) - $signed(SC'(j));
      rv = $signed(SR'(crow_b_q)) + $signed(SR'(r_i)) - $signed(SR'(j));
      cm[j] = rng[j] && (cv >= 0) && (cv < $signed(SC'(w_i)));
      rm[j] = rng[j] && (rv >= 0) && (rv < $signed(SR'(h_i)));
    end
  end

  // Level C: masks registered next to the updated window
  logic           vld_c_q, inf_c_q, last_c_q, fend_c_q;
  logic [WIN-1:0] cm_c_q, rm_c_q, rng_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (adv_i) begin
      vld_c_q <= vld_b_q & emit_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inf_c_q  <= inf_b_q;
      last_c_q <= last_b_q;
      fend_c_q <= fend_b_q;
      cm_c_q   <= cm;
      rm_c_q   <= rm;
      rng_c_q  <= rng;
    end
  end

  // Window reduction
  logic any_black, all_black;

  always_comb begin
    any_black = 1'b0;
    all_black = 1'b1;
    for (int j = 0; j < WIN; j++) begin
      any_black = any_black | (cm_c_q[j] & (|(rm_c_q & win_q[j])));
      all_black = all_black &
                  (~rng_c_q[j] | (cm_c_q[j] & (&(~rng_c_q | (rm_c_q & win_q[j])))));
    end
  end

  // Level D: stage output
  item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv_i) begin
      out_q.vld  <= vld_c_q;
      out_q.val  <= dil_i ? any_black : all_black;
      out_q.inf  <= inf_c_q;
      out_q.last <= last_c_q;
      out_q.fend <= fend_c_q;
    end
  end

  assign out_o = out_q;

  // Checks
  a_win_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> win_q[1] == $past(win_q[0]))
    else $error("window shift lost a column");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_i)
    else $error("column counter outside the row");

  // Forwarding flag only turns on after a write; it holds through stalls
  a_fwd_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(we))
    else $error("forwarding without a write");

endmodule

>>> rtl/binary_morphology_square_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_square_window_top
// Streaming binary dilate/erode/open/close with a square window.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid_i/in_ready_o, one per
//   transaction, 1 = black. After the frame's last pixel the source sends
//   drain items (flush_i, or any pixel) until the marked result comes out:
//   r*W + r drains for dilate/erode, twice that for opening/closing. A
//   flush_i before the frame is complete is dropped.
//   Results leave in raster order on out_valid_o/out_ready_i, the frame's
//   final one flagged by last_of_frame_o.
//   Throughput: one transaction per cycle on each side while the receiver
//   does not stall. Each window stage is three register levels (line
//   store read, mask, reduction). A result passes through one stage for
//   dilate/erode, two for opening/closing, after its window completes.
//   A stalled receiver freezes the whole pipeline; in_ready_o drops only
//   while a result is held. Configuration writes abort the current frame;
//   the user must issue them while the block is empty, the block itself
//   does not enforce this. Reset loads 640x480, radius 1, dilate. The line
//   stores need no clearing: rows above the frame are masked out.
// ----------------------------------------------------------------------------
module binary_morphology_square_window_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  bmsw_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [bmsw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                pixel_black_i,
  input  logic                                flush_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_black_o,
  output logic                                last_of_frame_o
);
  import bmsw_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT+1);
  localparam int unsigned RB = $clog2(MAX_RADIUS+1);
  localparam int unsigned DW = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned HC = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [2:0]            radius_q;
  op_e                   op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      radius_q <= RST_RADIUS;
      op_q     <= OP_DILATE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_RADIUS:       radius_q <= cfg_wdata_i[2:0];
        CFG_OPERATION:    op_q     <= op_e'(cfg_wdata_i[1:0]);
        default:          ;
      endcase
    end
  end

  // Effective geometry, clamped
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [RB-1:0]      r_eff;
  logic [RB+WW-1:0]   rw;
  logic [DW-1:0]      d;
  logic [DW:0]        sd;
  logic               two, first_dil;

  always_comb begin
    if (width_q == '0)                     w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
    else                                   w_eff = WW'(width_q);
    if (height_q == '0)                    h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT)   h_eff = HW'(MAX_HEIGHT);
    else                                   h_eff = HW'(height_q);
    if (radius_q == '0)                    r_eff = RB'(1);
    else if (32'(radius_q) > MAX_RADIUS)   r_eff = RB'(MAX_RADIUS);
    else                                   r_eff = RB'(radius_q);
  end

  assign rw        = (RB+WW)'(r_eff) * (RB+WW)'(w_eff);
  assign d         = DW'(rw) + DW'(r_eff);
  assign two       = (op_q == OP_OPEN) || (op_q == OP_CLOSE);
  assign first_dil = (op_q == OP_DILATE) || (op_q == OP_CLOSE);
  assign sd        = two ? {d, 1'b0} : {1'b0, d};

  // Flow control: everything moves unless a result is held
  logic adv, acc;
  item_t s1, s2, sel;

  assign sel         = two ? s2 : s1;
  assign out_valid_o = sel.vld & sel.inf;
  assign adv         = ~out_valid_o | out_ready_i;
  assign in_ready_o  = adv;
  assign acc         = in_valid_i & adv;

  // Frame sequencing: pixel phase, then drain phase
  logic          done_q, done_d;
  logic [CW-1:0] pcol_q, pcol_d;
  logic [HC-1:0] prow_q, prow_d;
  logic [DW:0]   drain_q, drain_d;
  logic          fend, s1_vld;

  assign fend   = done_q && (drain_q == sd - 1'b1);
  assign s1_vld = acc & (done_q | ~flush_i);

  always_comb begin
    done_d  = done_q;
    pcol_d  = pcol_q;
    prow_d  = prow_q;
    drain_d = drain_q;
    if (cfg_we_i) begin
      done_d  = 1'b0;
      pcol_d  = '0;
      prow_d  = '0;
      drain_d = '0;
    end else if (acc) begin
      if (done_q) begin
        if (fend) begin
          done_d  = 1'b0;
          drain_d = '0;
        end else begin
          drain_d = drain_q + 1'b1;
        end
      end else if (!flush_i) begin
        if (WW'(pcol_q) == w_eff - 1'b1) begin
          pcol_d = '0;
          if (HW'(prow_q) == h_eff - 1'b1) begin
            prow_d  = '0;
            done_d  = 1'b1;
            drain_d = '0;
          end else begin
            prow_d = prow_q + 1'b1;
          end
        end else begin
          pcol_d = pcol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      pcol_q  <= '0;
      prow_q  <= '0;
      drain_q <= '0;
    end else begin
      done_q  <= done_d;
      pcol_q  <= pcol_d;
      prow_q  <= prow_d;
      drain_q <= drain_d;
    end
  end

  // Window stages
  bmsw_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_stage1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .clr_i     (cfg_we_i),
    .dil_i     (first_dil),
    .w_i       (w_eff),
    .h_i       (h_eff),
    .r_i       (r_eff),
    .d_i       (d),
    .in_vld_i  (s1_vld),
    .in_pix_i  (pixel_black_i & ~done_q),
    .in_fend_i (fend),
    .out_o     (s1)
  );

  bmsw_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_stage2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .clr_i     (cfg_we_i),
    .dil_i     (~first_dil),
    .w_i       (w_eff),
    .h_i       (h_eff),
    .r_i       (r_eff),
    .d_i       (d),
    .in_vld_i  (s1.vld & two),
    .in_pix_i  (s1.val),
    .in_fend_i (s1.fend),
    .out_o     (s2)
  );

  assign result_black_o  = sel.val;
  assign last_of_frame_o = sel.last;

  // Checks
  a_done_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (pcol_q == '0) && (prow_q == '0))
    else $error("pixel counters active during drain");

  a_fend_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fend) |=> !done_q && (drain_q == '0))
    else $error("frame end did not restart the frame");

  a_drain_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> drain_q < sd)
    else $error("drain count past the window delay");

endmodule
